@@ rtl/sha1bs_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and rotate helpers for the sha-1 byte stream engine
// no dependencies

package sha1bs_pkg;

    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [6:0] ROUND_B1   = 7'd20;
    localparam logic [6:0] ROUND_B2   = 7'd40;
    localparam logic [6:0] ROUND_B3   = 7'd60;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [6:0] SCHED_WORDS = 7'd16;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_POS   = 6'd56;
    localparam logic [5:0] LAST_POS  = 6'd63;
    localparam logic [2:0] LAST_INDEX = 3'd4;

    typedef struct packed {
        logic       init;
        logic       step;
        logic       fold;
        logic       restart;
        logic [6:0] round;
    } round_ctl_t;

    typedef struct packed {
        logic       load_we;
        logic [3:0] load_addr;
        logic       step;
        logic [6:0] round;
        logic [6:0] fetch_round;
    } sched_ctl_t;

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        return {x[30:0], x[31]};
    endfunction

    function automatic logic [31:0] rotl5(input logic [31:0] x);
        return {x[26:0], x[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] x);
        return {x[1:0], x[31:2]};
    endfunction

endpackage

@@ rtl/sha1bs_sched.sv @@
`timescale 1ns / 1ps
// message schedule: 16-word memory with two registered read ports and one write port
// depends on sha1bs_pkg

module sha1bs_sched (
    input  logic                   clk,
    input  sha1bs_pkg::sched_ctl_t ctl,
    input  logic [31:0]            load_data,
    output logic [31:0]            w
);

    logic [31:0] mem [16];
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;
    logic [31:0] dly1_reg;
    logic [31:0] dly2_reg;
    logic [31:0] n1_reg;
    logic [31:0] n2_reg;
    logic [31:0] n3_reg;
    logic [3:0]  addr_a;
    logic [3:0]  addr_b;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;
    logic [31:0] mix;
    logic        expand;
    logic        wr_en;

    // port a: w[r] in the first sixteen rounds, w[r-8] after; port b: w[r-14]
    always_comb
    begin
        if (ctl.fetch_round < sha1bs_pkg::SCHED_WORDS)
        begin
            addr_a = ctl.fetch_round[3:0];
        end
        else
        begin
            addr_a = ctl.fetch_round[3:0] - 4'd8;
        end
        addr_b = ctl.fetch_round[3:0] + 4'd2;
    end

    assign expand  = (ctl.round >= sha1bs_pkg::SCHED_WORDS);
    // w[r-16] is the port b word read for round r-2, delayed in dly1_reg and dly2_reg
    assign mix     = rd_a_reg ^ rd_b_reg ^ dly2_reg ^ n3_reg;
    assign w       = expand ? sha1bs_pkg::rotl1(mix) : rd_a_reg;
    assign wr_en   = ctl.load_we | (ctl.step & expand);
    assign wr_addr = ctl.load_we ? ctl.load_addr : ctl.round[3:0];
    assign wr_data = ctl.load_we ? load_data : w;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            dly1_reg <= rd_b_reg;
            dly2_reg <= dly1_reg;
            n1_reg   <= w;
            n2_reg   <= n1_reg;
            n3_reg   <= n2_reg;
        end
    end

endmodule

@@ rtl/sha1bs_round.sv @@
`timescale 1ns / 1ps
// compression round datapath and the five chaining words
// depends on sha1bs_pkg

module sha1bs_round (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha1bs_pkg::round_ctl_t ctl,
    input  logic [31:0]            w,
    output logic [4:0][31:0]       chain
);

    logic [31:0]      a_reg;
    logic [31:0]      b_reg;
    logic [31:0]      c_reg;
    logic [31:0]      d_reg;
    logic [31:0]      e_reg;
    logic [4:0][31:0] chain_reg;
    logic [31:0]      f;
    logic [31:0]      k;
    logic [31:0]      t;

    always_comb
    begin
        if (ctl.round < sha1bs_pkg::ROUND_B1)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = sha1bs_pkg::K_R0;
        end
        else if (ctl.round < sha1bs_pkg::ROUND_B2)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1bs_pkg::K_R1;
        end
        else if (ctl.round < sha1bs_pkg::ROUND_B3)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = sha1bs_pkg::K_R2;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = sha1bs_pkg::K_R3;
        end
    end

    assign t     = sha1bs_pkg::rotl5(a_reg) + f + e_reg + k + w;
    assign chain = chain_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (ctl.step)
        begin
            a_reg <= t;
            b_reg <= a_reg;
            c_reg <= sha1bs_pkg::rotl30(b_reg);
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= sha1bs_pkg::H_INIT[i];
            end
        end
        else if (ctl.restart)
        begin
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= sha1bs_pkg::H_INIT[i];
            end
        end
        else if (ctl.fold)
        begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
            chain_reg[4] <= chain_reg[4] + e_reg;
        end
    end

endmodule

@@ rtl/sha1_byte_stream_hash.sv @@
`timescale 1ns / 1ps
// sha-1 byte stream engine top level: byte packing, padding, sequencing, digest output
// depends on sha1bs_pkg, sha1bs_sched, sha1bs_round
//
// input channel (in_valid / in_stall): one beat carries an optional message byte
// (byte_present) and an optional end-of-message mark (finish). output channel
// (out_valid / out_stall): five beats per message, digest words h0..h4 with
// word_index 0..4, last_word on the fifth.
// the beat that fills a 64-byte block starts a compression (a load state, 80
// rounds at one round per cycle from the schedule memory, a fold state);
// in_stall is high meanwhile. a finish beat pads one byte per cycle up to the
// end of the block (one or two blocks, each followed by its compression), and
// the first digest beat follows the fold of the last block; in_stall stays
// high until the last digest beat is taken, after which the engine holds its
// initial state for a new message.
// when the receiver stalls, the current digest word is held unchanged.
// reset clears the control state and loads the sha-1 initial chaining words;
// no clearing pass is needed.

module sha1_byte_stream_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        finish,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_LOAD  = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_FOLD  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [5:0]  fill_reg;
    logic [5:0]  fill_next;
    logic [23:0] word_reg;
    logic [63:0] len_reg;
    logic [63:0] len_next;
    logic [6:0]  round_reg;
    logic [6:0]  round_next;
    logic [2:0]  idx_reg;
    logic [2:0]  idx_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        fin_reg;
    logic        fin_next;
    logic        mark_reg;
    logic        mark_next;
    logic        lenblk_reg;
    logic        lenblk_next;
    logic        done_reg;
    logic        done_next;

    logic        byte_we;
    logic [7:0]  byte_val;
    logic [63:0] len_shift;
    logic        block_done;
    logic        out_take;
    logic [31:0] w;
    logic [4:0][31:0] chain;

    sha1bs_pkg::sched_ctl_t sched_ctl;
    sha1bs_pkg::round_ctl_t round_ctl;

    assign out_take  = out_valid_reg & ~out_stall;
    assign len_shift = len_reg >> {~fill_reg[2:0], 3'b000};

    // byte path shared by message bytes and padding
    always_comb
    begin
        byte_we  = 1'b0;
        byte_val = data_byte;
        case (state_reg)
            ST_IDLE:
            begin
                byte_we = in_valid & byte_present;
            end
            ST_PAD:
            begin
                byte_we = 1'b1;
                if (!mark_reg)
                begin
                    byte_val = sha1bs_pkg::PAD_MARK;
                end
                else if (lenblk_reg && (fill_reg >= sha1bs_pkg::LEN_POS))
                begin
                    byte_val = len_shift[7:0];
                end
                else
                begin
                    byte_val = 8'h00;
                end
            end
            default:
            begin
                byte_we = 1'b0;
            end
        endcase
    end

    assign block_done = byte_we & (fill_reg == sha1bs_pkg::LAST_POS);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = byte_we ? fill_reg + 6'd1 : fill_reg;
        len_next       = len_reg;
        round_next     = round_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        fin_next       = fin_reg;
        mark_next      = mark_reg;
        lenblk_next    = lenblk_reg;
        done_next      = done_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (byte_present)
                    begin
                        len_next = len_reg + 64'd8;
                    end
                    if (block_done)
                    begin
                        state_next = ST_LOAD;
                        fin_next   = finish;
                    end
                    else if (finish)
                    begin
                        state_next = ST_PAD;
                        fin_next   = 1'b1;
                    end
                end
            end
            ST_PAD:
            begin
                if (!mark_reg)
                begin
                    mark_next   = 1'b1;
                    lenblk_next = (fill_reg < sha1bs_pkg::LEN_POS);
                end
                if (block_done)
                begin
                    state_next = ST_LOAD;
                    done_next  = mark_reg & lenblk_reg;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_ROUND;
                round_next = 7'd0;
            end
            ST_ROUND:
            begin
                round_next = round_reg + 7'd1;
                if (round_reg == sha1bs_pkg::LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (done_reg)
                begin
                    state_next     = ST_OUT;
                    out_valid_next = 1'b1;
                    idx_next       = 3'd0;
                end
                else
                begin
                    state_next = ST_PAD;
                    if (mark_reg)
                    begin
                        lenblk_next = 1'b1;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_take)
                begin
                    if (idx_reg == sha1bs_pkg::LAST_INDEX)
                    begin
                        state_next     = ST_IDLE;
                        out_valid_next = 1'b0;
                        fin_next       = 1'b0;
                        mark_next      = 1'b0;
                        lenblk_next    = 1'b0;
                        done_next      = 1'b0;
                        len_next       = 64'd0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= 6'd0;
            len_reg       <= 64'd0;
            round_reg     <= 7'd0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
            fin_reg       <= 1'b0;
            mark_reg      <= 1'b0;
            lenblk_reg    <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            round_reg     <= round_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            fin_reg       <= fin_next;
            mark_reg      <= mark_next;
            lenblk_reg    <= lenblk_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            word_reg <= {word_reg[15:0], byte_val};
        end
    end

    always_comb
    begin
        sched_ctl.load_we     = byte_we & (fill_reg[1:0] == 2'b11);
        sched_ctl.load_addr   = fill_reg[5:2];
        sched_ctl.step        = (state_reg == ST_ROUND);
        sched_ctl.round       = round_reg;
        sched_ctl.fetch_round = (state_reg == ST_ROUND) ? round_reg + 7'd1 : 7'd0;
        round_ctl.init        = (state_reg == ST_LOAD);
        round_ctl.step        = (state_reg == ST_ROUND);
        round_ctl.fold        = (state_reg == ST_FOLD);
        round_ctl.restart     = out_take & (idx_reg == sha1bs_pkg::LAST_INDEX);
        round_ctl.round       = round_reg;
    end

    sha1bs_sched u_sched (
        .clk       (clk),
        .ctl       (sched_ctl),
        .load_data ({word_reg, byte_val}),
        .w         (w)
    );

    sha1bs_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (round_ctl),
        .w     (w),
        .chain (chain)
    );

    always_comb
    begin
        case (idx_reg)
            3'd0:    digest_word = chain[0];
            3'd1:    digest_word = chain[1];
            3'd2:    digest_word = chain[2];
            3'd3:    digest_word = chain[3];
            default: digest_word = chain[4];
        endcase
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign word_index = idx_reg;
    assign last_word  = (idx_reg == sha1bs_pkg::LAST_INDEX);

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (round_reg <= sha1bs_pkg::LAST_ROUND))
        else $error("round counter out of range");

    a_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (fill_reg == 6'd0))
        else $error("compression started on a partial block");

    a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg == (state_reg == ST_OUT))
        else $error("digest valid outside output state");

    a_digest_padded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> (done_reg && mark_reg && fill_reg == 6'd0))
        else $error("digest emitted before padding completed");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && idx_reg == sha1bs_pkg::LAST_INDEX)
        |=> (state_reg == ST_IDLE && len_reg == 64'd0 && !fin_reg))
        else $error("engine not restarted after last digest word");

endmodule

@@ dv/sha1_byte_stream_hash_check.sv @@
`timescale 1ns / 1ps
// watcher for the sha-1 byte stream engine: predicts digests from the byte channel and
// compares every digest beat; depends on sha1bs_pkg for the initial and round constants

module sha1_byte_stream_hash_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        finish,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last_word,
    output int          mismatch_count,
    output int          pending_words
);

    localparam int BLOCK_LEN = 64;
    localparam int LEN_AT    = 56;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  index;
        logic        is_last;
    } digest_beat_t;

    digest_beat_t digest_words_due[$];
    logic [31:0]  chain[5];
    logic [7:0]   block_bytes[BLOCK_LEN];
    int           fill;
    logic [63:0]  bit_count;

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic restart();
        int i;
        for (i = 0; i < 5; i++)
            chain[i] = sha1bs_pkg::H_INIT[i];
        fill = 0;
        bit_count = '0;
    endtask

    task automatic fold_block();
        logic [31:0] w[16];
        logic [31:0] a, b, c, d, e, f, k, t;
        int r;
        for (r = 0; r < 16; r++)
            w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2],
                    block_bytes[4*r+3]};
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (r = 0; r < 80; r++)
        begin
            if (r >= 16)
                w[r % 16] = rol(w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16]
                                ^ w[r % 16], 1);
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1bs_pkg::K_R0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = sha1bs_pkg::K_R1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1bs_pkg::K_R2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1bs_pkg::K_R3;
            end
            t = rol(a, 5) + f + e + k + w[r % 16];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endtask

    task automatic hash_beat(input logic [7:0] b, input logic present, input logic fin);
        logic [63:0]  total;
        digest_beat_t due;
        int i;
        if (present)
        begin
            block_bytes[fill] = b;
            fill++;
            if (fill == BLOCK_LEN)
            begin
                fold_block();
                bit_count += 64'd512;
                fill = 0;
            end
        end
        if (fin)
        begin
            total = bit_count + 64'(fill) * 64'd8;
            block_bytes[fill] = sha1bs_pkg::PAD_MARK;
            fill++;
            if (fill > LEN_AT)
            begin
                while (fill < BLOCK_LEN)
                begin
                    block_bytes[fill] = 8'h00;
                    fill++;
                end
                fold_block();
                fill = 0;
            end
            while (fill < LEN_AT)
            begin
                block_bytes[fill] = 8'h00;
                fill++;
            end
            for (i = 0; i < 8; i++)
                block_bytes[LEN_AT + i] = total[63 - 8*i -: 8];
            fold_block();
            for (i = 0; i < 5; i++)
            begin
                due.value = chain[i];
                due.index = 3'(i);
                due.is_last = (3'(i) == sha1bs_pkg::LAST_INDEX);
                digest_words_due.push_back(due);
            end
            restart();
        end
    endtask

    task automatic report(input string what);
        $display("%0t ns: digest beat mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        digest_beat_t due;
        if (!rst_n)
        begin
            restart();
            digest_words_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (digest_words_due.size() == 0)
                    report($sformatf("unexpected word %h index %0d", digest_word, word_index));
                else
                begin
                    due = digest_words_due.pop_front();
                    if (digest_word !== due.value)
                        report($sformatf("word %0d value %h, want %h",
                                         due.index, digest_word, due.value));
                    if (word_index !== due.index)
                        report($sformatf("index %0d, want %0d", word_index, due.index));
                    if (last_word !== due.is_last)
                        report($sformatf("last flag %b on word %0d, want %b",
                                         last_word, due.index, due.is_last));
                end
            end
            if (in_valid && !in_stall)
                hash_beat(data_byte, byte_present, finish);
        end
        pending_words = digest_words_due.size();
    end

endmodule

@@ dv/sha1_byte_stream_hash_test.sv @@
`timescale 1ns / 1ps
// top of the sha-1 byte stream engine testbench: clock, reset, message stimulus, verdict
// depends on sha1_byte_stream_hash and sha1_byte_stream_hash_check

module sha1_byte_stream_hash_test;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 1500;
    localparam int PHASE_ITEMS  = 12;
    localparam int TAIL_CYCLES  = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        byte_present = 1'b0;
    logic        finish = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    int mismatch_count;
    int pending_words;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int boundary_lens[6] = '{55, 56, 57, 63, 64, 65};

    always #5 clk = ~clk;

    sha1_byte_stream_hash uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .finish       (finish),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last_word    (last_word)
    );

    sha1_byte_stream_hash_check digest_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .finish         (finish),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_requests != hold_seen)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic offer(input logic [7:0] b, input logic present, input logic fin);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        byte_present <= present;
        finish <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
    endtask

    task automatic random_message();
        int  len;
        int  i;
        logic ends_on_byte;
        if ($urandom_range(9) < 7)
            len = $urandom_range(12);
        else
            len = boundary_lens[$urandom_range(5)];
        ends_on_byte = (len > 0) && ($urandom_range(1) == 1);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
                offer(8'($urandom), 1'b0, 1'b0);
            offer(8'($urandom), 1'b1, ends_on_byte && (i == len - 1));
            items_sent++;
        end
        if (!ends_on_byte)
        begin
            offer(8'($urandom), 1'b0, 1'b1);
            items_sent++;
        end
    endtask

    initial
    begin
        int phase;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message on a fresh engine, then an ignored beat before another empty one
        offer(8'hFF, 1'b0, 1'b1);
        offer(8'hA5, 1'b0, 1'b0);
        offer(8'h00, 1'b0, 1'b1);
        // "abc" closed by the last byte
        offer(8'h61, 1'b1, 1'b0);
        offer(8'h62, 1'b1, 1'b0);
        offer(8'h63, 1'b1, 1'b1);
        // byte extremes, closed by a beat with no byte
        offer(8'h00, 1'b1, 1'b0);
        offer(8'hFF, 1'b1, 1'b0);
        offer(8'h5A, 1'b0, 1'b0);
        offer(8'hFF, 1'b0, 1'b1);
        // single byte right after a digest
        offer(8'h80, 1'b1, 1'b1);
        settle();

        // long receiver hold-off while the sender keeps pushing
        hold_requests++;
        offer(8'h12, 1'b1, 1'b0);
        offer(8'h34, 1'b1, 1'b0);
        offer(8'h56, 1'b1, 1'b1);
        offer(8'h78, 1'b1, 1'b0);
        offer(8'h9A, 1'b0, 1'b1);
        offer(8'hBC, 1'b1, 1'b1);
        settle();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 86;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 86;
                end
                default:
                begin
                    send_idle_pct = 25;
                    stall_pct = 25;
                end
            endcase
            items_sent = 0;
            while (items_sent < PHASE_ITEMS)
                random_message();
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
